>>> src/mrrq_pkg.sv
// Package for the round-robin multi-channel packet queue.
// Holds default sizes, field widths, action, status and register codes.
// No dependencies.
package mrrq_pkg;

    localparam int DEF_PACKET_DEPTH    = 256;
    localparam int DEF_CHANNEL_SLOTS   = 32;
    localparam int DEF_HANDLE_BITS     = 16;
    localparam int DEF_MSG_NUMBER_BITS = 30;

    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int MAXC_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 30;

    localparam logic [MAXC_W-1:0] MAXC_RESET = 7'd16;

    localparam logic [ACTION_W-1:0] ACT_SINGLE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LIST   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TAKE   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STORE_FUL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_CHAN   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_CONC  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_MSG = 1'd1;

endpackage

>>> src/mrrq_if.sv
// Channel interfaces for the round-robin multi-channel packet queue.
// Depends on mrrq_pkg for field widths.
interface mrrq_req_if #(parameter int HANDLE_BITS = mrrq_pkg::DEF_HANDLE_BITS);
    logic                          valid;
    logic                          ready;
    logic [mrrq_pkg::ACTION_W-1:0] action;
    logic [HANDLE_BITS-1:0]        packet_handle;
    logic                          list_ordered;
    logic                          list_last;
    modport source (output valid, action, packet_handle, list_ordered, list_last, input ready);
    modport sink   (input valid, action, packet_handle, list_ordered, list_last, output ready);
endinterface

interface mrrq_rsp_if #(
    parameter int HANDLE_BITS     = mrrq_pkg::DEF_HANDLE_BITS,
    parameter int MSG_NUMBER_BITS = mrrq_pkg::DEF_MSG_NUMBER_BITS
);
    logic                          valid;
    logic                          ready;
    logic [mrrq_pkg::STATUS_W-1:0] status;
    logic                          packet_valid;
    logic [HANDLE_BITS-1:0]        packet_out;
    logic [MSG_NUMBER_BITS-1:0]    message_number;
    logic                          queue_empty;
    modport source (output valid, status, packet_valid, packet_out, message_number,
                    queue_empty, input ready);
    modport sink   (input valid, status, packet_valid, packet_out, message_number,
                    queue_empty, output ready);
endinterface

interface mrrq_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mrrq_pkg::CFG_IDX_W-1:0] index;
    logic [mrrq_pkg::CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/multi_channel_round_robin_queue_top.sv
// Top level of the round-robin multi-channel packet queue.
// Depends on mrrq_pkg and the channel interfaces in mrrq_if.sv.
//
//   channel | role   | moves
//   --------+--------+---------------------------------------------
//   req     | sink   | one request: action, handle, list flags
//   rsp     | source | one result per request
//   cfg     | sink   | register write: index, data
//
// Steps: action 3, a list item with no free channel or a take on an empty queue
// go straight to S_OUT; an enqueue reads the free-list link, then writes back;
// a take (when the pointer is on the empty main channel, first looking up the
// first list channel) reads the channel tables, then the packet store, then writes back.
// Reset: asynchronous, active low; no clearing pass, the memories are only
// read where written. Stalls: a finished result waits in the output register
// while the next request is worked on; a second result waits for it to leave.
module multi_channel_round_robin_queue_top #(
    parameter int PACKET_DEPTH    = mrrq_pkg::DEF_PACKET_DEPTH,
    parameter int CHANNEL_SLOTS   = mrrq_pkg::DEF_CHANNEL_SLOTS,
    parameter int HANDLE_BITS     = mrrq_pkg::DEF_HANDLE_BITS,
    parameter int MSG_NUMBER_BITS = mrrq_pkg::DEF_MSG_NUMBER_BITS
) (
    input logic       clk,
    input logic       rst_n,
    mrrq_req_if.sink  req,
    mrrq_rsp_if.source rsp,
    mrrq_cfg_if.sink  cfg
);

    localparam int PTR_W  = $clog2(PACKET_DEPTH);
    localparam int CNT_W  = $clog2(PACKET_DEPTH + 1);
    localparam int SLOT_W = $clog2(CHANNEL_SLOTS);
    localparam int MAXC_W = mrrq_pkg::MAXC_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_ALLOC  = 8'b0000_0010,
        S_COMMIT = 8'b0000_0100,
        S_TSEL   = 8'b0000_1000,
        S_TRD    = 8'b0001_0000,
        S_TPKT   = 8'b0010_0000,
        S_TFIN   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    // Memories: packet store and links, channel heads/tails, service order
    // kept doubly linked so a channel can be unlinked without a search.
    logic [HANDLE_BITS-1:0] handle_mem [PACKET_DEPTH];
    logic [PTR_W-1:0]       link_mem   [PACKET_DEPTH];
    logic [PTR_W-1:0]       head_mem   [CHANNEL_SLOTS];
    logic [PTR_W-1:0]       tail_mem   [CHANNEL_SLOTS];
    logic [SLOT_W-1:0]      olink_mem  [CHANNEL_SLOTS];
    logic [SLOT_W-1:0]      oprev_mem  [CHANNEL_SLOTS];

    logic [HANDLE_BITS-1:0] handle_rdata;
    logic [PTR_W-1:0]       link_rdata, head_rdata, tail_rdata;
    logic [SLOT_W-1:0]      olink_rdata, oprev_rdata;

    logic                   handle_we, link_we, head_we, tail_we, olink_we, oprev_we;
    logic [PTR_W-1:0]       handle_waddr, link_waddr, pkt_raddr;
    logic [HANDLE_BITS-1:0] handle_wdata;
    logic [PTR_W-1:0]       link_wdata, head_wdata, tail_wdata;
    logic [SLOT_W-1:0]      head_waddr, tail_waddr, olink_waddr, oprev_waddr, chan_raddr;
    logic [SLOT_W-1:0]      olink_wdata, oprev_wdata, olink_raddr;
    logic [PTR_W-1:0]       link_raddr;

    // Control state
    state_t                 state_reg, state_next;
    logic [PTR_W-1:0]       free_head_reg, free_head_next;
    logic [CNT_W-1:0]       free_count_reg, free_count_next;
    logic [CNT_W-1:0]       fresh_reg, fresh_next;
    logic [CNT_W-1:0]       main_count_reg, main_count_next;
    logic [PTR_W-1:0]       head0_reg, head0_next, tail0_reg, tail0_next;
    logic [SLOT_W-1:0]      order_tail_reg, order_tail_next;
    logic [CHANNEL_SLOTS-1:0] in_use_reg, in_use_next;
    logic [SLOT_W-1:0]      cur_reg, cur_next;
    logic [MAXC_W-1:0]      visited_reg, visited_next;
    logic [MSG_NUMBER_BITS-1:0] msg_reg, msg_next;
    logic [SLOT_W-1:0]      bld_slot_reg, bld_slot_next;
    logic [PTR_W-1:0]       bld_tail_reg, bld_tail_next;
    logic                   building_reg, building_next;
    logic [MAXC_W-1:0]      maxc_reg;

    // Request being worked on
    logic [mrrq_pkg::ACTION_W-1:0] act_reg;
    logic [HANDLE_BITS-1:0] hdl_reg;
    logic                   ord_reg, last_reg;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   via_link_reg, via_link_next;
    logic [SLOT_W-1:0]      c_reg, c_next;
    logic [PTR_W-1:0]       idx_reg, idx_next, ctail_reg, ctail_next;
    logic [SLOT_W-1:0]      nxt_reg, nxt_next, prev_reg, prev_next;

    // Result being built and the output register
    logic [mrrq_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                   res_pv_reg, res_pv_next;
    logic [HANDLE_BITS-1:0] res_pkt_reg, res_pkt_next;
    logic [MSG_NUMBER_BITS-1:0] res_msg_reg, res_msg_next;

    logic                   out_valid_reg;
    logic [mrrq_pkg::STATUS_W-1:0] out_status_reg;
    logic                   out_pv_reg, out_empty_reg;
    logic [HANDLE_BITS-1:0] out_pkt_reg;
    logic [MSG_NUMBER_BITS-1:0] out_msg_reg;

    logic                   req_fire, out_load;
    logic                   slot_found;
    logic [SLOT_W-1:0]      slot_free;
    logic                   q_empty;
    logic                   alloc_ok;
    logic [PTR_W-1:0]       alloc_idx;
    logic [SLOT_W-1:0]      c_sel, s_cur;
    logic                   at_end;
    logic [MAXC_W-1:0]      visited_inc;
    logic [31:0]            cfg_wide;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign cfg.ready  = 1'b1;
    assign q_empty    = (order_tail_reg == '0) && (main_count_reg == '0);
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || rsp.ready);
    assign cfg_wide   = 32'(cfg.data);

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.packet_valid   = out_pv_reg;
    assign rsp.packet_out     = out_pkt_reg;
    assign rsp.message_number = out_msg_reg;
    assign rsp.queue_empty    = out_empty_reg;

    // Lowest free non-main slot
    always_comb
    begin
        slot_found = 1'b0;
        slot_free  = '0;
        for (int i = CHANNEL_SLOTS - 1; i >= 1; i--)
        begin
            if (!in_use_reg[i])
            begin
                slot_found = 1'b1;
                slot_free  = SLOT_W'(i);
            end
        end
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (handle_we)
            handle_mem[handle_waddr] <= handle_wdata;
        handle_rdata <= handle_mem[pkt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        link_rdata <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        head_rdata <= head_mem[chan_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tail_we)
            tail_mem[tail_waddr] <= tail_wdata;
        tail_rdata <= tail_mem[chan_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (olink_we)
            olink_mem[olink_waddr] <= olink_wdata;
        olink_rdata <= olink_mem[olink_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (oprev_we)
            oprev_mem[oprev_waddr] <= oprev_wdata;
        oprev_rdata <= oprev_mem[chan_raddr];
    end

    // Sequencer: read, modify, write back
    always_comb
    begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        main_count_next = main_count_reg;
        head0_next      = head0_reg;
        tail0_next      = tail0_reg;
        order_tail_next = order_tail_reg;
        in_use_next     = in_use_reg;
        cur_next        = cur_reg;
        visited_next    = visited_reg;
        msg_next        = msg_reg;
        bld_slot_next   = bld_slot_reg;
        bld_tail_next   = bld_tail_reg;
        building_next   = building_reg;
        slot_next       = slot_reg;
        via_link_next   = via_link_reg;
        c_next          = c_reg;
        idx_next        = idx_reg;
        ctail_next      = ctail_reg;
        nxt_next        = nxt_reg;
        prev_next       = prev_reg;
        res_status_next = res_status_reg;
        res_pv_next     = res_pv_reg;
        res_pkt_next    = res_pkt_reg;
        res_msg_next    = res_msg_reg;

        handle_we    = 1'b0;
        handle_waddr = '0;
        handle_wdata = hdl_reg;
        link_we      = 1'b0;
        link_waddr   = '0;
        link_wdata   = '0;
        head_we      = 1'b0;
        head_waddr   = '0;
        head_wdata   = '0;
        tail_we      = 1'b0;
        tail_waddr   = '0;
        tail_wdata   = '0;
        olink_we     = 1'b0;
        olink_waddr  = '0;
        olink_wdata  = '0;
        oprev_we     = 1'b0;
        oprev_waddr  = '0;
        oprev_wdata  = '0;
        pkt_raddr    = idx_reg;
        link_raddr   = free_head_reg;
        chan_raddr   = c_reg;
        olink_raddr  = c_reg;

        alloc_ok    = 1'b0;
        alloc_idx   = '0;
        c_sel       = c_reg;
        s_cur       = bld_slot_reg;
        at_end      = (c_reg == order_tail_reg);
        visited_inc = visited_reg + 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_status_next = mrrq_pkg::ST_OK;
                    res_pv_next     = 1'b0;
                    res_pkt_next    = '0;
                    res_msg_next    = '0;
                    slot_next       = slot_free;
                    state_next      = S_OUT;
                    if (req.action == mrrq_pkg::ACT_SINGLE)
                        state_next = S_ALLOC;
                    else if (req.action == mrrq_pkg::ACT_LIST)
                    begin
                        // check channel first, store space afterwards
                        if (!building_reg && !slot_found)
                            res_status_next = mrrq_pkg::ST_NO_CHAN;
                        else
                            state_next = S_ALLOC;
                    end
                    else if (req.action == mrrq_pkg::ACT_TAKE)
                    begin
                        if (q_empty)
                            res_status_next = mrrq_pkg::ST_EMPTY;
                        else if (cur_reg == '0 && main_count_reg == '0)
                        begin
                            via_link_next = 1'b1;
                            state_next    = S_TSEL;
                        end
                        else
                        begin
                            via_link_next = 1'b0;
                            state_next    = S_TRD;
                        end
                    end
                end
            end

            S_ALLOC:
            begin
                // read the link of the free-list head
                link_raddr = free_head_reg;
                state_next = S_COMMIT;
            end

            S_COMMIT:
            begin
                if (free_count_reg != '0)
                begin
                    alloc_ok        = 1'b1;
                    alloc_idx       = free_head_reg;
                    free_head_next  = link_rdata;
                    free_count_next = free_count_reg - 1'b1;
                end
                else if (fresh_reg < CNT_W'(PACKET_DEPTH))
                begin
                    alloc_ok   = 1'b1;
                    alloc_idx  = fresh_reg[PTR_W-1:0];
                    fresh_next = fresh_reg + 1'b1;
                end
                handle_we    = alloc_ok;
                handle_waddr = alloc_idx;
                link_wdata   = alloc_idx;
                head_wdata   = alloc_idx;
                tail_wdata   = alloc_idx;
                state_next   = S_OUT;
                if (!alloc_ok)
                    res_status_next = mrrq_pkg::ST_STORE_FUL;

                if (act_reg == mrrq_pkg::ACT_SINGLE)
                begin
                    if (alloc_ok)
                    begin
                        if (main_count_reg == '0)
                            head0_next = alloc_idx;
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = tail0_reg;
                        end
                        tail0_next      = alloc_idx;
                        main_count_next = main_count_reg + 1'b1;
                    end
                end
                else
                begin
                    if (!building_reg)
                    begin
                        s_cur = slot_reg;
                        if (alloc_ok)
                        begin
                            in_use_next[slot_reg] = 1'b1;
                            bld_slot_next = slot_reg;
                            building_next = 1'b1;
                            bld_tail_next = alloc_idx;
                            head_we    = 1'b1;
                            head_waddr = slot_reg;
                            tail_we    = 1'b1;
                            tail_waddr = slot_reg;
                            if (ord_reg)
                            begin
                                msg_next     = msg_reg + 1'b1;
                                res_msg_next = msg_reg + 1'b1;
                            end
                        end
                    end
                    else if (alloc_ok)
                    begin
                        link_we       = 1'b1;
                        link_waddr    = bld_tail_reg;
                        tail_we       = 1'b1;
                        tail_waddr    = bld_slot_reg;
                        bld_tail_next = alloc_idx;
                    end

                    // close the list unless a first item was refused
                    if (last_reg && (building_reg || alloc_ok))
                    begin
                        olink_we        = 1'b1;
                        olink_waddr     = order_tail_reg;
                        olink_wdata     = s_cur;
                        oprev_we        = 1'b1;
                        oprev_waddr     = s_cur;
                        oprev_wdata     = order_tail_reg;
                        order_tail_next = s_cur;
                        building_next   = 1'b0;
                    end
                end
            end

            S_TSEL:
            begin
                olink_raddr = '0;
                state_next  = S_TRD;
            end

            S_TRD:
            begin
                c_sel       = via_link_reg ? olink_rdata : cur_reg;
                c_next      = c_sel;
                chan_raddr  = c_sel;
                olink_raddr = c_sel;
                state_next  = S_TPKT;
            end

            S_TPKT:
            begin
                idx_next   = (c_reg == '0) ? head0_reg : head_rdata;
                ctail_next = tail_rdata;
                nxt_next   = olink_rdata;
                prev_next  = oprev_rdata;
                pkt_raddr  = idx_next;
                link_raddr = idx_next;
                state_next = S_TFIN;
            end

            S_TFIN:
            begin
                res_pv_next  = 1'b1;
                res_pkt_next = handle_rdata;
                if (c_reg == '0)
                begin
                    main_count_next = main_count_reg - 1'b1;
                    head0_next      = link_rdata;
                end
                else if (idx_reg == ctail_reg)
                begin
                    // unlink the drained channel
                    olink_we    = 1'b1;
                    olink_waddr = prev_reg;
                    olink_wdata = nxt_reg;
                    if (at_end)
                        order_tail_next = prev_reg;
                    else
                    begin
                        oprev_we    = 1'b1;
                        oprev_waddr = nxt_reg;
                        oprev_wdata = prev_reg;
                    end
                    in_use_next[c_reg] = 1'b0;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_waddr = c_reg;
                    head_wdata = link_rdata;
                end
                link_we         = 1'b1;
                link_waddr      = idx_reg;
                link_wdata      = free_head_reg;
                free_head_next  = idx_reg;
                free_count_next = free_count_reg + 1'b1;
                if (at_end || visited_inc >= maxc_reg)
                begin
                    visited_next = '0;
                    cur_next     = '0;
                end
                else
                begin
                    visited_next = visited_inc;
                    cur_next     = nxt_reg;
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // load the message counter on a write to the start-message register
        if (cfg.valid && cfg.ready && cfg.index == mrrq_pkg::REG_START_MSG)
            msg_next = cfg_wide[MSG_NUMBER_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_head_reg  <= '0;
            free_count_reg <= '0;
            fresh_reg      <= '0;
            main_count_reg <= '0;
            order_tail_reg <= '0;
            in_use_reg     <= CHANNEL_SLOTS'(1);
            cur_reg        <= '0;
            visited_reg    <= '0;
            msg_reg        <= '0;
            bld_slot_reg   <= '0;
            building_reg   <= 1'b0;
            maxc_reg       <= mrrq_pkg::MAXC_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
            main_count_reg <= main_count_next;
            order_tail_reg <= order_tail_next;
            in_use_reg     <= in_use_next;
            cur_reg        <= cur_next;
            visited_reg    <= visited_next;
            msg_reg        <= msg_next;
            bld_slot_reg   <= bld_slot_next;
            building_reg   <= building_next;
            if (cfg.valid && cfg.ready && cfg.index == mrrq_pkg::REG_MAX_CONC)
                maxc_reg <= cfg.data[MAXC_W-1:0];
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        head0_reg      <= head0_next;
        tail0_reg      <= tail0_next;
        bld_tail_reg   <= bld_tail_next;
        slot_reg       <= slot_next;
        via_link_reg   <= via_link_next;
        c_reg          <= c_next;
        idx_reg        <= idx_next;
        ctail_reg      <= ctail_next;
        nxt_reg        <= nxt_next;
        prev_reg       <= prev_next;
        res_status_reg <= res_status_next;
        res_pv_reg     <= res_pv_next;
        res_pkt_reg    <= res_pkt_next;
        res_msg_reg    <= res_msg_next;
        if (req_fire)
        begin
            act_reg  <= req.action;
            hdl_reg  <= req.packet_handle;
            ord_reg  <= req.list_ordered;
            last_reg <= req.list_last;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_pv_reg     <= res_pv_reg;
            out_pkt_reg    <= res_pkt_reg;
            out_msg_reg    <= res_msg_reg;
            out_empty_reg  <= q_empty;
        end
    end

endmodule

>>> test/tb_multi_channel_round_robin_queue_top.sv
// Self-checking testbench for the round-robin multi-channel packet queue.
// Depends on mrrq_pkg, the channel interfaces in mrrq_if.sv and the top level.
`timescale 1ns / 1ps

module tb_multi_channel_round_robin_queue_top;

    localparam int PKT_DEPTH  = mrrq_pkg::DEF_PACKET_DEPTH;
    localparam int SLOTS      = mrrq_pkg::DEF_CHANNEL_SLOTS;
    localparam int HB         = mrrq_pkg::DEF_HANDLE_BITS;
    localparam int MB         = mrrq_pkg::DEF_MSG_NUMBER_BITS;
    localparam int CLK_PERIOD = 20;
    localparam int PEND_DEPTH = 16;

    // One result as the block reports it.
    typedef struct packed {
        logic [mrrq_pkg::STATUS_W-1:0] status;
        logic                          packet_valid;
        logic [HB-1:0]                 packet_out;
        logic [MB-1:0]                 message_number;
        logic                          queue_empty;
    } queue_result_t;

    logic clk;
    logic rst_n;

    mrrq_req_if #(.HANDLE_BITS(HB)) req_ch ();
    mrrq_rsp_if #(.HANDLE_BITS(HB), .MSG_NUMBER_BITS(MB)) rsp_ch ();
    mrrq_cfg_if cfg_ch ();

    multi_channel_round_robin_queue_top #(
        .PACKET_DEPTH(PKT_DEPTH),
        .CHANNEL_SLOTS(SLOTS),
        .HANDLE_BITS(HB),
        .MSG_NUMBER_BITS(MB)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch.sink),
        .rsp(rsp_ch.source),
        .cfg(cfg_ch.sink)
    );

    // ------------------------------------------------------------------
    // Predicted queue state: shared packet store, free list, channel
    // tables and the service order, all at the block's own sizes.
    // ------------------------------------------------------------------
    logic [HB-1:0]  pkt_handle [PKT_DEPTH];
    int             pkt_next   [PKT_DEPTH];
    int             free_head, free_count, fresh_count;
    int             chan_head  [SLOTS];
    int             chan_tail  [SLOTS];
    int             order_next [SLOTS];
    int             main_count, order_tail, current_slot, visited_count;
    logic [SLOTS-1:0] slot_busy;
    logic [MB-1:0]  msg_counter;
    int             build_slot;
    bit             build_open;
    logic [mrrq_pkg::MAXC_W-1:0] max_conc;

    // Predictions waiting for their results, oldest at pend_rd.
    queue_result_t pending [PEND_DEPTH];
    int            pend_wr;
    int            pend_rd;
    int            error_count;
    int            sender_idle_pct;
    int            rx_stall_pct;
    bit            rx_hold;

    // Take a free store entry: recycled entries first, then untouched ones.
    function automatic bit grab_entry(input logic [HB-1:0] h, output int idx);
        if (free_count > 0)
        begin
            idx = free_head;
            free_head = pkt_next[idx];
            free_count--;
        end
        else if (fresh_count < PKT_DEPTH)
        begin
            idx = fresh_count;
            fresh_count++;
        end
        else
            return 1'b0;
        pkt_handle[idx] = h;
        return 1'b1;
    endfunction

    function automatic bit queue_is_empty();
        return order_tail == 0 && main_count == 0;
    endfunction

    // Serve the front handle of the current channel and move the pointer on.
    function automatic void serve_take(inout queue_result_t r);
        int  c, p, idx, nxt;
        bit  at_end;
        if (queue_is_empty())
        begin
            r.status = mrrq_pkg::ST_EMPTY;
            return;
        end
        c = current_slot;
        if (c == 0 && main_count == 0)
            c = order_next[0];
        idx = chan_head[c];
        r.packet_valid = 1'b1;
        r.packet_out = pkt_handle[idx];
        at_end = (c == order_tail);
        nxt = order_next[c];
        if (c == 0)
        begin
            main_count--;
            chan_head[0] = pkt_next[idx];
        end
        else if (chan_head[c] == chan_tail[c])
        begin
            // Unlink the emptied channel from the service order.
            p = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (order_next[p] == c)
                    break;
                p = order_next[p];
            end
            order_next[p] = nxt;
            if (at_end)
                order_tail = p;
            slot_busy[c] = 1'b0;
        end
        else
            chan_head[c] = pkt_next[idx];
        pkt_next[idx] = free_head;
        free_head = idx;
        free_count++;
        current_slot = nxt;
        visited_count++;
        if (at_end || visited_count >= max_conc)
        begin
            visited_count = 0;
            current_slot = 0;
        end
    endfunction

    // Add one packet-list item; the first item opens a channel.
    function automatic void add_list_item(input logic [HB-1:0] h, input bit ordered,
                                          input bit last, inout queue_result_t r);
        int s, idx;
        bit found;
        if (!build_open)
        begin
            found = 1'b0;
            for (int i = 1; i < SLOTS; i++)
                if (!found && !slot_busy[i])
                begin
                    s = i;
                    found = 1'b1;
                end
            if (!found)
            begin
                r.status = mrrq_pkg::ST_NO_CHAN;
                return;
            end
            if (!grab_entry(h, idx))
            begin
                r.status = mrrq_pkg::ST_STORE_FUL;
                return;
            end
            slot_busy[s] = 1'b1;
            build_slot = s;
            build_open = 1'b1;
            chan_head[s] = idx;
            chan_tail[s] = idx;
            if (ordered)
            begin
                msg_counter = msg_counter + 1'b1;
                r.message_number = msg_counter;
            end
        end
        else
        begin
            s = build_slot;
            if (grab_entry(h, idx))
            begin
                pkt_next[chan_tail[s]] = idx;
                chan_tail[s] = idx;
            end
            else
                r.status = mrrq_pkg::ST_STORE_FUL;
        end
        if (last)
        begin
            order_next[order_tail] = build_slot;
            order_tail = build_slot;
            build_open = 1'b0;
        end
    endfunction

    function automatic queue_result_t advance_queue_model(
            input logic [mrrq_pkg::ACTION_W-1:0] act,
            input logic [HB-1:0] h, input bit ordered, input bit last);
        queue_result_t r;
        int idx;
        r = '0;
        r.status = mrrq_pkg::ST_OK;
        case (act)
            mrrq_pkg::ACT_SINGLE:
            begin
                if (grab_entry(h, idx))
                begin
                    if (main_count == 0)
                        chan_head[0] = idx;
                    else
                        pkt_next[chan_tail[0]] = idx;
                    chan_tail[0] = idx;
                    main_count++;
                end
                else
                    r.status = mrrq_pkg::ST_STORE_FUL;
            end
            mrrq_pkg::ACT_LIST: add_list_item(h, ordered, last, r);
            mrrq_pkg::ACT_TAKE: serve_take(r);
            default: ;
        endcase
        r.queue_empty = queue_is_empty();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, time limit and result checking
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Generous limit: far beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Drive ready at random, or hold it low during a long hold-off,
    // and compare every accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        queue_result_t got, want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{rsp_ch.status, rsp_ch.packet_valid, rsp_ch.packet_out,
                    rsp_ch.message_number, rsp_ch.queue_empty};
            if (pend_wr == pend_rd)
            begin
                $display("%0t: unexpected result %p", $time, got);
                error_count++;
            end
            else
            begin
                want = pending[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (got.status !== want.status || got.packet_valid !== want.packet_valid ||
                    got.packet_out !== want.packet_out ||
                    got.message_number !== want.message_number ||
                    got.queue_empty !== want.queue_empty)
                begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                    error_count++;
                end
            end
        end
        if (rx_hold)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------

    // Offer one request, hold it until accepted, then record its prediction.
    // Valid stays high afterwards unless a random idle gap drops it, so back-to-back requests follow without a break.
    task automatic send_request(input logic [mrrq_pkg::ACTION_W-1:0] act,
                                input logic [HB-1:0] h, input bit ordered, input bit last);
        int gap;
        req_ch.valid         <= 1'b1;
        req_ch.action        <= act;
        req_ch.packet_handle <= h;
        req_ch.list_ordered  <= ordered;
        req_ch.list_last     <= last;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending[pend_wr % PEND_DEPTH] = advance_queue_model(act, h, ordered, last);
        pend_wr++;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every result is in, then let the block settle.
    task automatic drain_queue();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pend_wr != pend_rd)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_register(input logic [mrrq_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [mrrq_pkg::CFG_DAT_W-1:0] value);
        drain_queue();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == mrrq_pkg::REG_MAX_CONC)
            max_conc = value[mrrq_pkg::MAXC_W-1:0];
        else
            msg_counter = value[MB-1:0];
    endtask

    // One packet list of n items with random content; the last one closes it when closes is set.
    task automatic send_list(input int n, input bit closes);
        for (int i = 0; i < n; i++)
            send_request(mrrq_pkg::ACT_LIST, HB'($urandom), 1'($urandom_range(1)),
                         closes && (i == n - 1));
    endtask

    // Mostly well-formed traffic with random content, some noise and unclosed lists.
    task automatic send_mix(input int count, input int enq_pct);
        int sent, r, n;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(99);
            if (r < enq_pct)
            begin
                r = $urandom_range(99);
                if (r < 40)
                begin
                    send_request(mrrq_pkg::ACT_SINGLE, HB'($urandom),
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
                    sent++;
                end
                else if (r < 92)
                begin
                    n = ($urandom_range(9) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(1, 5);
                    send_list(n, $urandom_range(19) != 0);
                    sent += n;
                end
                else
                begin
                    send_request(mrrq_pkg::ACTION_W'($urandom), HB'($urandom),
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
                    sent++;
                end
            end
            else
            begin
                send_request(mrrq_pkg::ACT_TAKE, HB'($urandom), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    task automatic take_until_empty();
        while (!queue_is_empty() || build_open)
        begin
            if (build_open)
                send_request(mrrq_pkg::ACT_LIST, HB'($urandom), 1'b0, 1'b1);
            else
                send_request(mrrq_pkg::ACT_TAKE, '0, 1'b0, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every action and the documented corner cases.
    task automatic test_directed();
        send_request(mrrq_pkg::ACT_TAKE, '0, 1'b0, 1'b0);        // take on an empty queue
        send_request(mrrq_pkg::ACT_NONE, '1, 1'b1, 1'b1);        // unused action
        send_request(mrrq_pkg::ACT_SINGLE, '0, 1'b0, 1'b0);
        send_request(mrrq_pkg::ACT_SINGLE, '1, 1'b1, 1'b1);
        send_request(mrrq_pkg::ACT_LIST, 16'h1234, 1'b1, 1'b0);  // ordered list opens
        send_request(mrrq_pkg::ACT_TAKE, '0, 1'b0, 1'b0);        // ignores the open list
        send_request(mrrq_pkg::ACT_LIST, 16'h5678, 1'b0, 1'b0);
        send_request(mrrq_pkg::ACT_LIST, 16'h9abc, 1'b0, 1'b1);
        send_request(mrrq_pkg::ACT_LIST, 16'hfffe, 1'b0, 1'b1);  // one-item unordered list
        send_request(mrrq_pkg::ACT_LIST, 16'h0001, 1'b1, 1'b1);
        repeat (8) send_request(mrrq_pkg::ACT_TAKE, '1, 1'b1, 1'b1);
        write_register(mrrq_pkg::REG_START_MSG, '1);             // counter wraps to zero
        send_request(mrrq_pkg::ACT_LIST, 16'h00ff, 1'b1, 1'b1);
        send_request(mrrq_pkg::ACT_LIST, 16'hff00, 1'b1, 1'b1);
        take_until_empty();
    endtask

    // Exhaust the channels, then the packet store, including a list that
    // hits a full store mid-way and still closes.
    task automatic test_resource_limits();
        repeat (SLOTS) send_request(mrrq_pkg::ACT_LIST, HB'($urandom), 1'b1, 1'b1);
        take_until_empty();
        repeat (PKT_DEPTH - 3) send_request(mrrq_pkg::ACT_SINGLE, HB'($urandom), 1'b0, 1'b0);
        send_list(6, 1'b1);                                   // runs out part way
        send_list(2, 1'b1);                                   // full on the first item
        take_until_empty();
    endtask

    // Hold the receiver off while requests keep coming so the block backs up.
    // The hold-off is counted down in a process of its own.
    task automatic test_backpressure();
        drain_queue();
        fork
            begin
                rx_hold = 1'b1;
                repeat (400) @(posedge clk);
                rx_hold = 1'b0;
            end
        join_none
        send_mix(150, 70);
        take_until_empty();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int count, input int enq_pct);
        drain_queue();
        sender_idle_pct = idle_pct;
        rx_stall_pct    = stall_pct;
        send_mix(count, enq_pct);
    endtask

    // Run traffic under each round-robin limit, the extremes among them.
    task automatic test_round_robin_limits();
        write_register(mrrq_pkg::REG_MAX_CONC, mrrq_pkg::CFG_DAT_W'(1));
        write_register(mrrq_pkg::REG_START_MSG, '0);
        test_random_phase(0, 0, 180, 55);
        write_register(mrrq_pkg::REG_MAX_CONC, mrrq_pkg::CFG_DAT_W'(64));
        write_register(mrrq_pkg::REG_START_MSG, 30'h3fff_fff0);
        test_random_phase(48, 0, 180, 50);
        write_register(mrrq_pkg::REG_MAX_CONC, '0);
        test_random_phase(0, 48, 180, 50);
        write_register(mrrq_pkg::REG_MAX_CONC, mrrq_pkg::CFG_DAT_W'(127));
        write_register(mrrq_pkg::REG_START_MSG, mrrq_pkg::CFG_DAT_W'($urandom));
        test_random_phase(25, 25, 180, 60);
        write_register(mrrq_pkg::REG_MAX_CONC,
                       mrrq_pkg::CFG_DAT_W'($urandom_range(2, 20)));
        test_random_phase(0, 0, 200, 65);
        test_random_phase(25, 25, 180, 40);
    endtask

    initial
    begin
        sender_idle_pct = 0;
        rx_stall_pct    = 0;
        // Predicted reset state.
        free_head = 0; free_count = 0; fresh_count = 0; main_count = 0;
        order_tail = 0; current_slot = 0; visited_count = 0;
        slot_busy = SLOTS'(1); msg_counter = '0; build_slot = 0; build_open = 1'b0;
        max_conc = mrrq_pkg::MAXC_RESET;

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.action        = mrrq_pkg::ACT_SINGLE;
        req_ch.packet_handle = '0;
        req_ch.list_ordered  = 1'b0;
        req_ch.list_last     = 1'b0;
        rsp_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = mrrq_pkg::REG_MAX_CONC;
        cfg_ch.data          = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_resource_limits();
        test_backpressure();
        test_round_robin_limits();

        drain_queue();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
src/mrrq_pkg.sv
src/mrrq_if.sv
src/multi_channel_round_robin_queue_top.sv
test/tb_multi_channel_round_robin_queue_top.sv
